[design/nearest_waypoint_within_limit_macros.svh]
// assertion macros shared by the nearest waypoint search modules
`ifndef NEAREST_WAYPOINT_WITHIN_LIMIT_MACROS_SVH
`define NEAREST_WAYPOINT_WITHIN_LIMIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define NWL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define NWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/nwl_pkg.sv]
// shared types and constants for the nearest waypoint search
`default_nettype none

package nwl_pkg;

    // distance limit register
    localparam int unsigned LIMIT_W     = 23;
    localparam int unsigned LIMIT_SQ_W  = 2 * LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd256;

    // function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_APPENDED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_MATCH    = 2'd2;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_QSTART,
        S_WALK,
        S_DRAIN
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic append;
        logic q_init;
        logic issue;
        logic q_done;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic last_issue;
        logic busy;
    } t_sts;

endpackage

`default_nettype wire

[design/nwl_ctrl.sv]
// controller state machine for the nearest waypoint search
`default_nettype none
`include "nearest_waypoint_within_limit_macros.svh"

module nwl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_func,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output nwl_pkg::t_cmd      o_cmd,
    input  wire nwl_pkg::t_sts i_sts
);
    import nwl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   out_load;

    // output register can take a result this cycle
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_func == FUNC_QUERY) ? S_QSTART : S_APPEND;
                end
            end
            S_APPEND: begin
                if (out_free) begin
                    o_cmd.append = 1'b1;
                    out_load     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_QSTART: begin
                o_cmd.q_init = 1'b1;
                n_state = i_sts.empty ? S_DRAIN : S_WALK;
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy && out_free) begin
                    o_cmd.q_done = 1'b1;
                    out_load     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // a result never overwrites one that is still waiting
    `NWL_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, out_load,
        !r_out_valid || i_out_ready, "result loaded over a pending transfer")
    // a walk ends only through the drain state
    `NWL_ASSERT_NEXT(a_walk_exit, i_clk, i_rst_n, r_state == S_WALK,
        r_state == S_WALK || r_state == S_DRAIN, "walk left without draining")
    // results wait for the search pipeline to empty
    `NWL_ASSERT_NOW(a_done_idle_pipe, i_clk, i_rst_n, o_cmd.q_done,
        !i_sts.busy && !o_cmd.issue, "query finished with entries in flight")

endmodule

`default_nettype wire

[design/nwl_dp.sv]
// datapath: waypoint table, distance pipeline and best-match tracking
`default_nettype none
`include "nearest_waypoint_within_limit_macros.svh"

module nwl_dp #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned COORD_WIDTH = 24,
    parameter int unsigned IDX_W       = $clog2(MAX_ENTRIES)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [nwl_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  wire logic [COORD_WIDTH-1:0]       i_coord_x,
    input  wire logic [COORD_WIDTH-1:0]       i_coord_y,
    input  wire nwl_pkg::t_cmd                i_cmd,
    output nwl_pkg::t_sts                     o_sts,
    output logic [1:0]                        o_status,
    output logic [IDX_W-1:0]                  o_entry_index
);
    import nwl_pkg::*;

    localparam int unsigned CW    = COORD_WIDTH;
    localparam int unsigned DW    = CW + 1;
    localparam int unsigned SQW   = 2 * DW;
    localparam int unsigned SUMW  = SQW + 1;
    localparam int unsigned CMPW  = (SUMW > LIMIT_SQ_W) ? SUMW : LIMIT_SQ_W;
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    // waypoint table
    logic [CW-1:0] mem_x [MAX_ENTRIES];
    logic [CW-1:0] mem_y [MAX_ENTRIES];

    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_addr;
    logic [CW-1:0]      r_px;
    logic [CW-1:0]      r_py;
    logic               full;

    // pipeline stages
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]   r_i1, r_i2, r_i3, r_i4;
    logic [CW-1:0]      r_rd_x, r_rd_y;
    logic [DW-1:0]      r_dx, r_dy;
    logic [SQW-1:0]     r_sq_x, r_sq_y;
    logic [SUMW-1:0]    r_d2;
    logic [DW-1:0]      n_diff_x, n_diff_y;
    logic [DW-1:0]      n_abs_x, n_abs_y;

    // best match so far
    logic [CMPW-1:0]    r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_found;
    logic               hit;

    logic [1:0]         r_status;
    logic [IDX_W-1:0]   r_index;

    assign full = (r_count == CNT_MAX);

    // status to the controller
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.last_issue = ({1'b0, r_addr} == (r_count - CNT_W'(1)));
    assign o_sts.busy       = r_v1 | r_v2 | r_v3 | r_v4;

    // distance limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // input point capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // table write on append
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            mem_x[r_count[IDX_W-1:0]] <= r_px;
            mem_y[r_count[IDX_W-1:0]] <= r_py;
        end
    end

    // table read for the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_x <= mem_x[r_addr];
            r_rd_y <= mem_y[r_addr];
        end
    end

    // entry count and walk address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
        end else begin
            if (i_cmd.append && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.q_init) begin
                r_addr <= '0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // absolute coordinate differences
    always_comb begin
        n_diff_x = {r_px[CW-1], r_px} - {r_rd_x[CW-1], r_rd_x};
        n_diff_y = {r_py[CW-1], r_py} - {r_rd_y[CW-1], r_rd_y};
        n_abs_x  = n_diff_x[DW-1] ? (~n_diff_x + DW'(1)) : n_diff_x;
        n_abs_y  = n_diff_y[DW-1] ? (~n_diff_y + DW'(1)) : n_diff_y;
    end

    // difference, square and sum stages
    always_ff @(posedge i_clk) begin
        r_i1   <= r_addr;
        r_i2   <= r_i1;
        r_i3   <= r_i2;
        r_i4   <= r_i3;
        r_dx   <= n_abs_x;
        r_dy   <= n_abs_y;
        r_sq_x <= SQW'(r_dx) * SQW'(r_dx);
        r_sq_y <= SQW'(r_dy) * SQW'(r_dy);
        r_d2   <= SUMW'(r_sq_x) + SUMW'(r_sq_y);
    end

    // strict compare keeps the lowest slot on ties
    assign hit = r_v4 && (CMPW'(r_d2) < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.q_init) begin
            r_found <= 1'b0;
        end else if (hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_best     <= CMPW'(LIMIT_SQ_W'(r_limit) * LIMIT_SQ_W'(r_limit));
            r_best_idx <= '0;
        end else if (hit) begin
            r_best     <= CMPW'(r_d2);
            r_best_idx <= r_i4;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_status <= full ? STATUS_FULL : STATUS_APPENDED;
            r_index  <= full ? '0 : r_count[IDX_W-1:0];
        end else if (i_cmd.q_done) begin
            r_status <= r_found ? STATUS_MATCH : STATUS_NO_MATCH;
            r_index  <= r_found ? r_best_idx : '0;
        end
    end

    assign o_status      = r_status;
    assign o_entry_index = r_index;

    // the walk never reads past the loaded entries
    `NWL_ASSERT_NOW(a_issue_in_range, i_clk, i_rst_n, i_cmd.issue,
        CNT_W'(r_addr) < r_count, "walk read beyond loaded entries")
    // a match always names a loaded slot
    `NWL_ASSERT_NOW(a_best_loaded, i_clk, i_rst_n, r_found,
        CNT_W'(r_best_idx) < r_count, "best slot not loaded")
    // the entry count grows only by one append
    `NWL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, !i_cmd.append,
        r_count == $past(r_count), "entry count changed without append")

endmodule

`default_nettype wire

[design/nearest_waypoint_within_limit.sv]
// top level of the nearest waypoint search with distance limit
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_func, i_coord_x, i_coord_y
//  out      | output    | o_out_valid / i_out_ready| o_status, o_entry_index
//  config   | input     | i_cfg_we (no wait)       | i_cfg_wdata
//
// an append holds the block through S_APPEND, and its result is registered once the
// output register is free; a query holds it through S_QSTART, S_WALK and S_DRAIN
// (an empty table goes straight to S_DRAIN): one table read per cycle through the
// single read port, then a four-stage distance pipeline drains.
// reset empties the table by clearing the entry count; no clearing pass runs.
// a new item is taken while a result waits; the next result stalls until the out transfer.
`default_nettype none

module nearest_waypoint_within_limit #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned COORD_WIDTH = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [nwl_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_func,
    input  wire logic [COORD_WIDTH-1:0]      i_coord_x,
    input  wire logic [COORD_WIDTH-1:0]      i_coord_y,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic [$clog2(MAX_ENTRIES)-1:0]   o_entry_index
);
    import nwl_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);

    t_cmd cmd;
    t_sts sts;

    // controller
    nwl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // datapath
    nwl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_entry_index (o_entry_index)
    );

endmodule

`default_nettype wire

[sim/nearest_waypoint_within_limit_checker.sv]
`timescale 1ns / 100ps
// checker for the nearest waypoint search: predicts each answer and compares it on the out channel
module nearest_waypoint_within_limit_checker #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned COORD_WIDTH = 24,
    parameter int unsigned IDX_W       = $clog2(MAX_ENTRIES)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [nwl_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic                        i_func,
    input  wire logic [COORD_WIDTH-1:0]      i_coord_x,
    input  wire logic [COORD_WIDTH-1:0]      i_coord_y,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [1:0]                  i_status,
    input  wire logic [IDX_W-1:0]            i_entry_index,
    output int                               o_pending,
    output int                               o_mismatches
);
    import nwl_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] entry_index;
    } t_waypoint_answer;

    // own copy of the waypoint table, entry count and limit
    logic [COORD_WIDTH-1:0] wp_x [MAX_ENTRIES];
    logic [COORD_WIDTH-1:0] wp_y [MAX_ENTRIES];
    int                     loaded_count = 0;
    logic [LIMIT_W-1:0]     radius = LIMIT_RESET;

    t_waypoint_answer       answers_q [$];
    t_waypoint_answer       oldest;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    // append stores at the next free slot; query keeps the first strictly closer entry
    function automatic t_waypoint_answer nearest_waypoint_answer(
        input logic                   func,
        input logic [COORD_WIDTH-1:0] cx,
        input logic [COORD_WIDTH-1:0] cy
    );
        t_waypoint_answer  ans;
        longint            qx;
        longint            qy;
        longint            dx;
        longint            dy;
        longint unsigned   best;
        longint unsigned   d2;
        int                i;
        ans.entry_index = '0;
        if (func == FUNC_APPEND) begin
            if (loaded_count >= MAX_ENTRIES) begin
                ans.status = STATUS_FULL;
            end else begin
                wp_x[loaded_count] = cx;
                wp_y[loaded_count] = cy;
                ans.status         = STATUS_APPENDED;
                ans.entry_index    = IDX_W'(loaded_count);
                loaded_count++;
            end
        end else begin
            qx         = longint'($signed(cx));
            qy         = longint'($signed(cy));
            best       = 64'(radius) * 64'(radius);
            ans.status = STATUS_NO_MATCH;
            for (i = 0; i < loaded_count; i++) begin
                dx = qx - longint'($signed(wp_x[i]));
                dy = qy - longint'($signed(wp_y[i]));
                d2 = longint'(dx * dx + dy * dy);
                if (d2 < best) begin
                    best            = d2;
                    ans.entry_index = IDX_W'(i);
                    ans.status      = STATUS_MATCH;
                end
            end
        end
        return ans;
    endfunction

    // out transfer is checked before the in transfer of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loaded_count = 0;
            radius       = LIMIT_RESET;
            answers_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_q.size() == 0) begin
                    flag_mismatch($sformatf("result status %0d index %0d with nothing outstanding",
                                            i_status, i_entry_index));
                end else begin
                    oldest = answers_q.pop_front();
                    if (i_status !== oldest.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                i_status, oldest.status));
                    if (i_entry_index !== oldest.entry_index)
                        flag_mismatch($sformatf("entry index %0d, expected %0d (status %0d)",
                                                i_entry_index, oldest.entry_index, oldest.status));
                end
            end
            if (i_cfg_we)
                radius = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                answers_q = {answers_q, nearest_waypoint_answer(i_func, i_coord_x, i_coord_y)};
        end
        o_pending = answers_q.size();
    end

endmodule

[sim/nearest_waypoint_within_limit_tb.sv]
`timescale 1ns / 100ps
// testbench top for the nearest waypoint search: stimulus, limit writes and verdict
module nearest_waypoint_within_limit_tb;
    import nwl_pkg::*;

    localparam int unsigned MAX_ENTRIES  = 1024;
    localparam int unsigned COORD_W      = 24;
    localparam int unsigned IDX_W        = $clog2(MAX_ENTRIES);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam logic [COORD_W-1:0] POS_MAX   = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] NEG_MAX   = 24'h800000;
    localparam logic [COORD_W-1:0] MINUS_ONE = 24'hFFFFFF;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 5000;
    localparam int SEG_ITEMS     = 70;
    localparam int GROW_ITEMS    = 90;
    localparam int TAIL_ITEMS    = 24;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_func   = FUNC_APPEND;
    logic [COORD_W-1:0]    in_x      = '0;
    logic [COORD_W-1:0]    in_y      = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [1:0]            out_status;
    logic [IDX_W-1:0]      out_index;
    int                    pending;
    int                    mismatches;

    // stimulus bookkeeping: points actually stored, for shaping queries
    logic [COORD_W-1:0]    stored_x [$];
    logic [COORD_W-1:0]    stored_y [$];
    logic [LIMIT_W-1:0]    cur_limit = LIMIT_RESET;
    bit                    quiet = 1'b0;
    int                    hold_requests = 0;
    int                    holds_done = 0;
    int                    hold_left = 0;
    int                    burst_left = 0;
    int                    n_items = 0;
    int                    n_dropped = 0;
    int                    n_queries = 0;
    int                    n_limit_writes = 0;

    always #1 clk = ~clk;

    nearest_waypoint_within_limit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_func        (in_func),
        .i_coord_x     (in_x),
        .i_coord_y     (in_y),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (out_status),
        .o_entry_index (out_index)
    );

    nearest_waypoint_within_limit_checker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_WIDTH (COORD_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_func        (in_func),
        .i_coord_x     (in_x),
        .i_coord_y     (in_y),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (out_status),
        .i_entry_index (out_index),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    // receiver: one long hold-off on request, else random stall bursts
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (!quiet && burst_left > 0) begin
            burst_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // base moved by up to spread on one axis, wrapping at the coordinate width
    function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] base,
                                                  input int unsigned spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - int'(spread);
        return base + COORD_W'(off);
    endfunction

    function automatic int pick_stored();
        return $urandom_range(0, stored_x.size() - 1);
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 3))
            0:       return POS_MAX;
            1:       return NEG_MAX;
            2:       return MINUS_ONE;
            default: return '0;
        endcase
    endfunction

    // append point: duplicates, near neighbors, extremes, clusters and full range
    function automatic void gen_append(output logic [COORD_W-1:0] x,
                                       output logic [COORD_W-1:0] y);
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (stored_x.size() == 0 && r < 4)
            r = 9;
        k = (stored_x.size() > 0) ? pick_stored() : 0;
        if (r < 2) begin
            x = stored_x[k];
            y = stored_y[k];
        end else if (r < 4) begin
            x = jitter(stored_x[k], int'(cur_limit) + 1);
            y = jitter(stored_y[k], int'(cur_limit) + 1);
        end else if (r == 4) begin
            x = extreme_coord();
            y = extreme_coord();
        end else if (r < 7) begin
            x = jitter('0, 4096);
            y = jitter('0, 4096);
        end else begin
            x = rand_coord();
            y = rand_coord();
        end
    endfunction

    // query point: mostly close to a stored point so the walk finds matches
    function automatic void gen_query(output logic [COORD_W-1:0] x,
                                      output logic [COORD_W-1:0] y);
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (stored_x.size() == 0)
            r = 9;
        k = (stored_x.size() > 0) ? pick_stored() : 0;
        if (r < 6) begin
            x = jitter(stored_x[k], int'(cur_limit) + 1);
            y = jitter(stored_y[k], int'(cur_limit) + 1);
        end else if (r < 8) begin
            x = stored_x[k];
            y = stored_y[k];
        end else if (r == 8) begin
            x = jitter('0, 4096);
            y = jitter('0, 4096);
        end else begin
            x = rand_coord();
            y = rand_coord();
        end
    endfunction

    // one in transfer, with an optional idle burst before it
    task automatic send_item(input logic f, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        int gap;
        gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_func  <= f;
        in_x     <= x;
        in_y     <= y;
        do @(posedge clk); while (!in_ready);
        n_items++;
        if (f == FUNC_QUERY) begin
            n_queries++;
        end else if (stored_x.size() < MAX_ENTRIES) begin
            stored_x = {stored_x, x};
            stored_y = {stored_y, y};
        end else begin
            n_dropped++;
        end
    endtask

    task automatic send_random(input int append_pct);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        if ($urandom_range(0, 99) < append_pct) begin
            gen_append(x, y);
            send_item(FUNC_APPEND, x, y);
        end else begin
            gen_query(x, y);
            send_item(FUNC_QUERY, x, y);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_limit = value;
        n_limit_writes++;
    endtask

    // query exactly at the most recently stored point
    task automatic query_last_slot();
        send_item(FUNC_QUERY, stored_x[stored_x.size()-1], stored_y[stored_y.size()-1]);
    endtask

    initial begin
        int seg;
        int n;
        int waited;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, strict limit, equal distances, zero and max limit
        send_item(FUNC_QUERY,  24'd0,    24'd0);
        send_item(FUNC_APPEND, 24'd0,    24'd0);
        send_item(FUNC_APPEND, POS_MAX,  POS_MAX);
        send_item(FUNC_APPEND, NEG_MAX,  NEG_MAX);
        send_item(FUNC_APPEND, 24'd255,  24'd0);
        send_item(FUNC_APPEND, 24'd0,    24'd0);
        send_item(FUNC_APPEND, 24'd1000, 24'd0);
        send_item(FUNC_APPEND, 24'd1200, 24'd0);
        send_item(FUNC_QUERY,  24'd0,    24'd0);
        send_item(FUNC_QUERY,  24'd128,  24'd0);
        send_item(FUNC_QUERY,  24'd256,  24'd0);
        send_item(FUNC_QUERY,  24'd0,    24'd256);
        send_item(FUNC_QUERY,  POS_MAX,  POS_MAX);
        send_item(FUNC_QUERY,  NEG_MAX,  NEG_MAX);
        send_item(FUNC_QUERY,  POS_MAX,  NEG_MAX);
        send_item(FUNC_QUERY,  24'd1100, 24'd0);
        send_item(FUNC_QUERY,  24'd1100, 24'd50);
        set_limit('0);
        send_item(FUNC_QUERY,  24'd0,    24'd0);
        set_limit(LIMIT_MAX);
        send_item(FUNC_QUERY,  24'd0,    POS_MAX);
        send_item(FUNC_QUERY,  24'd1,    POS_MAX);
        send_item(FUNC_QUERY,  MINUS_ONE, MINUS_ONE);

        // random segments over a small table, one limit per segment
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       set_limit('0);
                1:       set_limit(LIMIT_W'(1));
                2:       set_limit(LIMIT_W'($urandom_range(2, 300)));
                3:       set_limit(LIMIT_W'($urandom_range(300, 100000)));
                4:       set_limit(LIMIT_MAX);
                default: set_limit(LIMIT_W'($urandom_range(0, LIMIT_MAX)));
            endcase
            // long receiver hold-off while items keep coming
            if (seg == 2)
                hold_requests++;
            for (n = 0; n < SEG_ITEMS; n++)
                send_random(35);
        end

        // grow the table with mostly appends, a few queries on the way
        set_limit(LIMIT_W'($urandom_range(1000, 200000)));
        for (n = 0; n < GROW_ITEMS; n++)
            send_random(90);

        // larger table: longer walks under the maximum and a random limit
        set_limit(LIMIT_MAX);
        query_last_slot();
        for (n = 0; n < TAIL_ITEMS; n++)
            send_random(50);
        set_limit(LIMIT_W'($urandom_range(1, LIMIT_MAX)));
        quiet = 1'b1;
        for (n = 0; n < TAIL_ITEMS; n++)
            send_random(50);
        query_last_slot();

        // drain the last results, bounded
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_CYCLES) begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (pending != 0)
            $display("%0d results never arrived", pending);

        $display("covered %0d items: %0d appends stored, %0d dropped on a full table, %0d queries",
                 n_items, stored_x.size(), n_dropped, n_queries);
        $display("limit written %0d times incl. zero and maximum; one %0d-cycle receiver hold-off",
                 n_limit_writes, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("[nearest_waypoint_within_limit] OK");
        end else begin
            $display("[nearest_waypoint_within_limit] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10000000;
        $display("timeout with %0d results outstanding", pending);
        $display("[nearest_waypoint_within_limit] ERROR");
        $finish;
    end

endmodule
